FILE: design/nbi_pkg.sv
// types, codes and arithmetic helpers for the backward difference interpolator
package nbi_pkg;

	localparam int MAX_POINTS_DEF = 16;
	localparam int PC_W           = 5;
	localparam int DIV_W          = 49;
	localparam int DSR_W          = 33;
	localparam int DCNT_W         = 6;
	localparam int WIDE_W         = 66;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_QUERY = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_FEW  = 2'd2,
		ST_ZERO = 2'd3
	} stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_LOAD,
		S_DIVI,
		S_DIV,
		S_PSET,
		S_M1,
		S_M2,
		S_M3,
		S_M4,
		S_M5,
		S_M6,
		S_QEND,
		S_FIN
	} state_t;

	typedef struct packed {
		logic start;
		logic decode;
		logic load_step;
		logic div_init;
		logic div_step;
		logic p_set;
		logic m1;
		logic m2;
		logic m3;
		logic m4;
		logic m5;
		logic m6;
		logic q_end;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		op_t   op;
		stat_t dec_status;
		logic  load_last;
		logic  div_last;
		logic  has_terms;
		logic  mac_last;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [31:0] r;
		if (v > 66'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -66'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	// shift right 16, round half away from zero
	function automatic logic signed [WIDE_W-1:0] rnd16(input logic signed [WIDE_W-1:0] v);
		logic [WIDE_W-1:0] mag;
		logic [WIDE_W-1:0] r;
		mag = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
		r = (mag + WIDE_W'(32768)) >> 16;
		return v[WIDE_W-1] ? -$signed(r) : $signed(r);
	endfunction

	// 1/k! as unsigned Q.32
	function automatic logic [32:0] inv_fact(input logic [4:0] k);
		logic [32:0] r;
		case (k)
			5'd0:    r = 33'd4294967296;
			5'd1:    r = 33'd4294967296;
			5'd2:    r = 33'd2147483648;
			5'd3:    r = 33'd715827883;
			5'd4:    r = 33'd178956971;
			5'd5:    r = 33'd35791394;
			5'd6:    r = 33'd5965232;
			5'd7:    r = 33'd852176;
			5'd8:    r = 33'd106522;
			5'd9:    r = 33'd11836;
			5'd10:   r = 33'd1184;
			5'd11:   r = 33'd108;
			5'd12:   r = 33'd9;
			5'd13:   r = 33'd1;
			default: r = 33'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: design/nbi_ctrl.sv
// controller state machine sequencing clear, load and query words
module nbi_ctrl import nbi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				if (sts.op == OP_LOAD && sts.dec_status == ST_OK)
					state_d = S_LOAD;
				else if (sts.op == OP_QUERY && sts.dec_status == ST_OK)
					state_d = S_DIVI;
				else
					state_d = S_FIN;
			end
			S_LOAD: begin
				cmd.load_step = 1'b1;
				if (sts.load_last)
					state_d = S_FIN;
			end
			S_DIVI: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_d = S_PSET;
			end
			S_PSET: begin
				cmd.p_set = 1'b1;
				state_d   = sts.has_terms ? S_M1 : S_QEND;
			end
			S_M1: begin
				cmd.m1  = 1'b1;
				state_d = S_M2;
			end
			S_M2: begin
				cmd.m2  = 1'b1;
				state_d = S_M3;
			end
			S_M3: begin
				cmd.m3  = 1'b1;
				state_d = S_M4;
			end
			S_M4: begin
				cmd.m4  = 1'b1;
				state_d = S_M5;
			end
			S_M5: begin
				cmd.m5  = 1'b1;
				state_d = S_M6;
			end
			S_M6: begin
				cmd.m6  = 1'b1;
				state_d = sts.mac_last ? S_QEND : S_M1;
			end
			S_QEND: begin
				cmd.q_end = 1'b1;
				state_d   = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

FILE: design/nbi_dpath.sv
// datapath: difference column, x registers, divider and multiply-accumulate
module nbi_dpath import nbi_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic               cfg_write_en,
	input  logic [PC_W-1:0]    cfg_write_data,
	input  logic [1:0]         operation,
	input  logic signed [31:0] sample_x,
	input  logic signed [31:0] sample_y,
	input  logic signed [31:0] query_x,
	output logic signed [31:0] interpolated_value,
	output logic [1:0]         status
);

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	logic signed [31:0]      col_q [MAX_POINTS];
	logic [PC_W-1:0]         pc_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [31:0]      x_first_q, x_second_q, x_last_q;
	op_t                     op_q;
	logic signed [31:0]      sx_q, sy_q, qx_q;
	logic signed [31:0]      carry_q;
	logic [IDX_W-1:0]        k_q;
	logic [DIV_W-1:0]        dvd_q;
	logic [DSR_W-1:0]        dvs_q;
	logic [DSR_W-1:0]        rem_q;
	logic                    qneg_q;
	logic [DCNT_W-1:0]       dcnt_q;
	logic signed [31:0]      p_q;
	logic signed [31:0]      prod_q;
	logic signed [WIDE_W-1:0] mult_q;
	logic [64:0]             mag_q;
	logic signed [33:0]      coef_q;
	logic signed [63:0]      acc_q;
	logic signed [31:0]      res_value_q;
	stat_t                   res_status_q;
	logic signed [31:0]      out_value_q;
	stat_t                   out_status_q;

	logic [CNT_W-1:0]        n_eff;
	stat_t                   dec_status;
	logic signed [31:0]      col_k;
	logic signed [32:0]      num, hsp;
	logic [DSR_W-1:0]        num_mag, h_mag;
	logic [DSR_W:0]          trial;
	logic signed [33:0]      kofs, factor;
	logic [31:0]             pmag;
	logic signed [33:0]      cmag;

	assign col_k = col_q[k_q];

	always_comb begin
		if (pc_q < PC_W'(2))
			n_eff = CNT_W'(2);
		else if (int'(pc_q) > MAX_POINTS)
			n_eff = CNT_W'(MAX_POINTS);
		else
			n_eff = CNT_W'(pc_q);
	end

	always_comb begin
		dec_status = ST_OK;
		case (op_q)
			OP_LOAD: begin
				if (cnt_q >= n_eff)
					dec_status = ST_FULL;
			end
			OP_QUERY: begin
				if (cnt_q < n_eff)
					dec_status = ST_FEW;
				else if (x_second_q == x_first_q)
					dec_status = ST_ZERO;
			end
			default: dec_status = ST_OK;
		endcase
	end

	always_comb begin
		num     = $signed({qx_q[31], qx_q}) - $signed({x_last_q[31], x_last_q});
		hsp     = $signed({x_second_q[31], x_second_q}) - $signed({x_first_q[31], x_first_q});
		num_mag = num[32] ? DSR_W'(-num) : DSR_W'(num);
		h_mag   = hsp[32] ? DSR_W'(-hsp) : DSR_W'(hsp);
		trial   = {rem_q, dvd_q[DIV_W-1]} - {1'b0, dvs_q};
		kofs    = $signed(34'(k_q - IDX_W'(1)) << 16);
		factor  = 34'(p_q) + kofs;
		pmag    = prod_q[31] ? 32'(-prod_q) : 32'(prod_q);
		cmag    = $signed(34'(mag_q[64:32]) + 34'(mag_q[31]));
	end

	assign sts.op         = op_q;
	assign sts.dec_status = dec_status;
	assign sts.load_last  = (CNT_W'(k_q) == cnt_q);
	assign sts.div_last   = (dcnt_q == DCNT_W'(DIV_W - 1));
	assign sts.has_terms  = (cnt_q > CNT_W'(1));
	assign sts.mac_last   = (CNT_W'(k_q) == cnt_q - CNT_W'(1));

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= PC_W'(4);
			cnt_q      <= '0;
			x_first_q  <= '0;
			x_second_q <= '0;
			x_last_q   <= '0;
		end else begin
			if (cfg_write_en)
				pc_q <= cfg_write_data;
			if (cmd.decode && op_q == OP_CLEAR) begin
				cnt_q      <= '0;
				x_first_q  <= '0;
				x_second_q <= '0;
				x_last_q   <= '0;
			end
			if (cmd.load_step && sts.load_last) begin
				if (cnt_q == CNT_W'(0))
					x_first_q <= sx_q;
				if (cnt_q == CNT_W'(1))
					x_second_q <= sx_q;
				x_last_q <= sx_q;
				cnt_q    <= cnt_q + CNT_W'(1);
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q <= op_t'(operation);
			sx_q <= sample_x;
			sy_q <= sample_y;
			qx_q <= query_x;
		end
		if (cmd.decode) begin
			res_value_q  <= '0;
			res_status_q <= dec_status;
			carry_q      <= sy_q;
			k_q          <= '0;
		end
		if (cmd.load_step) begin
			col_q[k_q] <= carry_q;
			if (!sts.load_last) begin
				carry_q <= sat32(WIDE_W'(carry_q) - WIDE_W'(col_k));
				k_q     <= k_q + IDX_W'(1);
			end
		end
		if (cmd.div_init) begin
			dvd_q  <= {num_mag, 16'b0};
			dvs_q  <= h_mag;
			qneg_q <= num[32] ^ hsp[32];
			rem_q  <= '0;
			dcnt_q <= '0;
			k_q    <= IDX_W'(1);
			prod_q <= 32'sd65536;
			acc_q  <= 64'(col_q[0]);
		end
		if (cmd.div_step) begin
			if (!trial[DSR_W]) begin
				rem_q <= trial[DSR_W-1:0];
				dvd_q <= {dvd_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DSR_W-2:0], dvd_q[DIV_W-1]};
				dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
			end
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end
		if (cmd.p_set)
			p_q <= sat32(qneg_q ? -$signed(WIDE_W'(dvd_q)) : $signed(WIDE_W'(dvd_q)));
		if (cmd.m1)
			mult_q <= WIDE_W'(prod_q) * WIDE_W'(factor);
		if (cmd.m2)
			prod_q <= sat32(rnd16(mult_q));
		if (cmd.m3)
			mag_q <= 65'(pmag) * 65'(inv_fact(5'(k_q)));
		if (cmd.m4)
			coef_q <= prod_q[31] ? -cmag : cmag;
		if (cmd.m5)
			mult_q <= WIDE_W'(coef_q) * WIDE_W'(col_k);
		if (cmd.m6) begin
			acc_q <= acc_q + 64'(rnd16(mult_q));
			k_q   <= k_q + IDX_W'(1);
		end
		if (cmd.q_end)
			res_value_q <= sat32(WIDE_W'(acc_q));
		if (cmd.out_load) begin
			out_value_q  <= res_value_q;
			out_status_q <= res_status_q;
		end
	end

	assign interpolated_value = out_value_q;
	assign status             = out_status_q;

endmodule

FILE: design/newton_backward_interpolator_top.sv
// top level of the newton backward difference interpolator
// Usage: one input word per operation (clear, load point, query, no-op) on
// in_valid/in_stall; exactly one result word (interpolated_value, status) per
// input word on out_valid/out_stall. point_count is written through
// cfg_write_en/cfg_write_data while the block is idle.
// Words are taken one at a time; in_stall is high from acceptance until the
// result is placed in the output register.
// Clear, no-op, rejected loads and rejected queries go from decode straight
// to the output; a load into a table of m points updates one difference
// entry per cycle; a query over c loaded points runs the 49-step bit-serial
// divider for p, then one multiply-accumulate pass (M1 to M6) per order.
// The output register holds a finished word, so the next input word is
// accepted while the result still waits on out_stall; a second result waits
// in the datapath until the output register is free.
// Reset clears the loaded count and x registers and sets point_count to 4;
// the difference column needs no clearing.
module newton_backward_interpolator_top import nbi_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic signed [31:0] sample_x,
	input  logic signed [31:0] sample_y,
	input  logic signed [31:0] query_x,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] interpolated_value,
	output logic [1:0]         status,
	input  logic               cfg_write_en,
	input  logic [PC_W-1:0]    cfg_write_data
);

	cmd_t cmd;
	sts_t sts;

	nbi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	nbi_dpath #(
		.MAX_POINTS (MAX_POINTS)
	) u_dpath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.cfg_write_en       (cfg_write_en),
		.cfg_write_data     (cfg_write_data),
		.operation          (operation),
		.sample_x           (sample_x),
		.sample_y           (sample_y),
		.query_x            (query_x),
		.interpolated_value (interpolated_value),
		.status             (status)
	);

endmodule
